// ===== sv/lsq3_pkg.sv =====
// Shared constants, types and helper functions for the 3-unknown least squares solver.
// Used by every module of the block; depends on nothing.
package lsq3_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int MAX_ROWS     = 1024;
   localparam int ROWS_W       = $clog2(MAX_ROWS + 1);
   localparam int SUM_W        = 2 * SAMPLE_WIDTH + ROWS_W;
   localparam int DET_W        = 3 * SUM_W + 2;
   localparam int Q_FRAC       = 16;
   localparam int SOL_W        = 32;
   localparam int DIV_N        = DET_W + Q_FRAC;
   localparam int DIV_CNT_W    = $clog2(DIV_N);
   localparam int MUL_CNT_W    = $clog2(SUM_W);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int STEP_W       = 4;
   localparam int DSEL_W       = 2;

   localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;
   localparam logic [DSEL_W-1:0] DSEL_DET  = 2'd0;
   localparam logic [DSEL_W-1:0] DSEL_LAST = 2'd3;
   localparam logic [SOL_W-1:0]  SOL_MAX   = 32'h7FFF_FFFF;
   localparam logic [SOL_W-1:0]  SOL_MIN   = 32'h8000_0000;

   // normal matrix upper triangle S00 S01 S02 S11 S12 S22, then F^T b
   typedef struct packed {
      logic [5:0][SUM_W-1:0] nrm;
      logic [2:0][SUM_W-1:0] rhs;
   } sums_type;

   typedef struct packed {
      logic [3:0] a_idx;
      logic [3:0] b_idx;
      logic       use_t;
      logic [1:0] t_sel;
      logic       negate;
      logic       clear;
   } step_type;

   typedef struct packed {
      logic             start;
      logic [DET_W-1:0] mcand;
      logic [SUM_W-1:0] mplier;
      logic [DET_W-1:0] init;
   } mul_cmd_type;

   typedef struct packed {
      logic             done;
      logic [DET_W-1:0] acc;
   } mul_rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_GO,
      BK_MUL_WAIT,
      BK_DIV,
      BK_EMIT
   } back_state_type;

   // Entry idx (row-major) of the matrix for determinant dsel:
   // 0 is the normal matrix, 1..3 replace that column by F^T b.
   function automatic logic [SUM_W-1:0] mat_entry(sums_type s, logic [DSEL_W-1:0] dsel,
                                                  logic [3:0] idx);
      logic [1:0] row;
      logic [1:0] col;
      logic [2:0] nidx;
      logic [SUM_W-1:0] r;
      case (idx)
         4'd0: begin row = 2'd0; col = 2'd0; nidx = 3'd0; end
         4'd1: begin row = 2'd0; col = 2'd1; nidx = 3'd1; end
         4'd2: begin row = 2'd0; col = 2'd2; nidx = 3'd2; end
         4'd3: begin row = 2'd1; col = 2'd0; nidx = 3'd1; end
         4'd4: begin row = 2'd1; col = 2'd1; nidx = 3'd3; end
         4'd5: begin row = 2'd1; col = 2'd2; nidx = 3'd4; end
         4'd6: begin row = 2'd2; col = 2'd0; nidx = 3'd2; end
         4'd7: begin row = 2'd2; col = 2'd1; nidx = 3'd4; end
         4'd8: begin row = 2'd2; col = 2'd2; nidx = 3'd5; end
         default: begin row = 2'd0; col = 2'd0; nidx = 3'd0; end
      endcase
      if (dsel != DSEL_DET && (col + 2'd1) == dsel) begin
         r = s.rhs[row];
      end else begin
         r = s.nrm[nidx];
      end
      return r;
   endfunction

   // Cofactor expansion along the first row as nine multiply-accumulates.
   function automatic step_type step_plan(logic [STEP_W-1:0] s);
      step_type p;
      p = '0;
      case (s)
         4'd0: begin p.a_idx = 4'd4; p.b_idx = 4'd8; p.clear = 1'b1; end
         4'd1: begin p.a_idx = 4'd5; p.b_idx = 4'd7; p.negate = 1'b1; end
         4'd2: begin p.a_idx = 4'd3; p.b_idx = 4'd8; p.clear = 1'b1; end
         4'd3: begin p.a_idx = 4'd5; p.b_idx = 4'd6; p.negate = 1'b1; end
         4'd4: begin p.a_idx = 4'd3; p.b_idx = 4'd7; p.clear = 1'b1; end
         4'd5: begin p.a_idx = 4'd4; p.b_idx = 4'd6; p.negate = 1'b1; end
         4'd6: begin p.use_t = 1'b1; p.t_sel = 2'd0; p.b_idx = 4'd0; p.clear = 1'b1; end
         4'd7: begin p.use_t = 1'b1; p.t_sel = 2'd1; p.b_idx = 4'd1; p.negate = 1'b1; end
         4'd8: begin p.use_t = 1'b1; p.t_sel = 2'd2; p.b_idx = 4'd2; end
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

// ===== sv/lsq3_front.sv =====
// Front end: takes rows, accumulates the normal-equation sums, hands them off on the last row.
// Depends on lsq3_pkg.
module lsq3_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [lsq3_pkg::SAMPLE_WIDTH-1:0] req_coef_0,
   input  logic signed [lsq3_pkg::SAMPLE_WIDTH-1:0] req_coef_1,
   input  logic signed [lsq3_pkg::SAMPLE_WIDTH-1:0] req_coef_2,
   input  logic signed [lsq3_pkg::SAMPLE_WIDTH-1:0] req_target,
   input  logic                                 req_last_row,
   input  logic                                 q_full,
   output logic                                 q_push,
   output lsq3_pkg::sums_type                   q_data
);
   import lsq3_pkg::*;

   sums_type          sums_ff, sums_in, sums_row;
   logic [ROWS_W-1:0] rows_ff, rows_in;
   logic              accept, grow;
   logic signed [2*SAMPLE_WIDTH-1:0] p00, p01, p02, p11, p12, p22, r0, r1, r2;

   always_comb begin
      p00 = req_coef_0 * req_coef_0;
      p01 = req_coef_0 * req_coef_1;
      p02 = req_coef_0 * req_coef_2;
      p11 = req_coef_1 * req_coef_1;
      p12 = req_coef_1 * req_coef_2;
      p22 = req_coef_2 * req_coef_2;
      r0  = req_coef_0 * req_target;
      r1  = req_coef_1 * req_target;
      r2  = req_coef_2 * req_target;

      accept = req_push && !q_full;
      grow   = rows_ff < ROWS_W'(MAX_ROWS);

      sums_row = sums_ff;
      if (grow) begin
         sums_row.nrm[0] = sums_ff.nrm[0] + SUM_W'(p00);
         sums_row.nrm[1] = sums_ff.nrm[1] + SUM_W'(p01);
         sums_row.nrm[2] = sums_ff.nrm[2] + SUM_W'(p02);
         sums_row.nrm[3] = sums_ff.nrm[3] + SUM_W'(p11);
         sums_row.nrm[4] = sums_ff.nrm[4] + SUM_W'(p12);
         sums_row.nrm[5] = sums_ff.nrm[5] + SUM_W'(p22);
         sums_row.rhs[0] = sums_ff.rhs[0] + SUM_W'(r0);
         sums_row.rhs[1] = sums_ff.rhs[1] + SUM_W'(r1);
         sums_row.rhs[2] = sums_ff.rhs[2] + SUM_W'(r2);
      end

      sums_in = sums_ff;
      rows_in = rows_ff;
      if (accept) begin
         if (req_last_row) begin
            sums_in = '0;
            rows_in = '0;
         end else begin
            sums_in = sums_row;
            rows_in = grow ? rows_ff + ROWS_W'(1) : rows_ff;
         end
      end

      req_full = q_full;
      q_push   = accept && req_last_row;
      q_data   = sums_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
         rows_ff <= '0;
      end else begin
         sums_ff <= sums_in;
         rows_ff <= rows_in;
      end
   end

endmodule

// ===== sv/lsq3_queue.sv =====
// Short queue of finished sum sets between the front end and the solver.
// Depends on lsq3_pkg.
module lsq3_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lsq3_pkg::sums_type data_in,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output lsq3_pkg::sums_type data_out
);
   import lsq3_pkg::*;

   sums_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   always_comb begin
      full     = cnt_ff == QCNT_W'(QUEUE_DEPTH);
      empty    = cnt_ff == '0;
      do_push  = push && !full;
      do_pop   = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in   = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
      data_out = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

// ===== sv/lsq3_mul.sv =====
// Serial signed multiply-accumulate: acc = init + mcand * mplier, one multiplier bit a cycle.
// Depends on lsq3_pkg.
module lsq3_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  lsq3_pkg::mul_cmd_type cmd,
   output lsq3_pkg::mul_rsp_type rsp
);
   import lsq3_pkg::*;

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic [DET_W-1:0]     acc_ff, acc_in, a_ff, addend;
   logic [SUM_W-1:0]     b_ff;
   logic                 last;

   always_comb begin
      last   = cnt_ff == MUL_CNT_W'(SUM_W - 1);
      addend = b_ff[0] ? a_ff : '0;
      // top multiplier bit carries negative weight
      acc_in = last ? acc_ff - addend : acc_ff + addend;
      busy_in = busy_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
      end else if (busy_ff && last) begin
         busy_in = 1'b0;
      end
      done_in = busy_ff && last && !cmd.start;
      rsp.done = done_ff;
      rsp.acc  = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= cmd.init;
         a_ff   <= cmd.mcand;
         b_ff   <= cmd.mplier;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         a_ff   <= a_ff << 1;
         b_ff   <= b_ff >> 1;
         cnt_ff <= cnt_ff + MUL_CNT_W'(1);
      end
   end

endmodule

// ===== sv/lsq3_back.sv =====
// Back end: serial-MAC 3x3 determinants (four, one if singular), divides, holds the result.
// Depends on lsq3_pkg; drives lsq3_mul through a command struct.
module lsq3_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  lsq3_pkg::sums_type               q_data,
   output logic                             q_pop,
   output lsq3_pkg::mul_cmd_type            mul_cmd,
   input  lsq3_pkg::mul_rsp_type            mul_rsp,
   input  logic                             rsp_pop,
   output logic                             rsp_empty,
   output logic signed [lsq3_pkg::SOL_W-1:0] rsp_solution_0,
   output logic signed [lsq3_pkg::SOL_W-1:0] rsp_solution_1,
   output logic signed [lsq3_pkg::SOL_W-1:0] rsp_solution_2,
   output logic                             rsp_singular,
   output logic                             rsp_saturated
);
   import lsq3_pkg::*;

   back_state_type       state_ff, state_in;
   sums_type             job_ff;
   step_type             plan;
   logic [STEP_W-1:0]    step_ff;
   logic [DSEL_W-1:0]    dsel_ff;
   logic [DET_W-1:0]     acc_ff, det_ff, t_ff [3];
   logic [DET_W-1:0]     res_mag, det_mag, mcand;
   logic [DIV_N-1:0]     num_ff;
   logic [DET_W-1:0]     den_ff;
   logic [DET_W:0]       rem_ff, rem_in, rtry;
   logic [SOL_W-1:0]     quo_ff, q_fin, sol_val;
   logic                 big_ff, big_fin, neg_ff, ge, sol_sat;
   logic [DIV_CNT_W-1:0] dcnt_ff;
   logic [SOL_W-1:0]     sol_ff [3];
   logic                 sing_ff, sat_ff, out_valid_ff, out_valid_in;
   logic                 det_zero, div_last, out_free, step_end;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) state_in = BK_MUL_GO;
         end
         BK_MUL_GO: state_in = BK_MUL_WAIT;
         BK_MUL_WAIT: begin
            if (mul_rsp.done) begin
               if (!step_end) begin
                  state_in = BK_MUL_GO;
               end else if (dsel_ff == DSEL_DET) begin
                  state_in = det_zero ? BK_EMIT : BK_MUL_GO;
               end else begin
                  state_in = BK_DIV;
               end
            end
         end
         BK_DIV: begin
            if (div_last) state_in = (dsel_ff == DSEL_LAST) ? BK_EMIT : BK_MUL_GO;
         end
         BK_EMIT: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and datapath helpers
   always_comb begin
      plan     = step_plan(step_ff);
      step_end = step_ff == STEP_LAST;
      det_zero = mul_rsp.acc == '0;
      res_mag  = mul_rsp.acc[DET_W-1] ? -mul_rsp.acc : mul_rsp.acc;
      det_mag  = det_ff[DET_W-1] ? -det_ff : det_ff;
      out_free = !out_valid_ff || rsp_pop;

      if (plan.use_t) begin
         mcand = t_ff[plan.t_sel];
      end else begin
         mcand = DET_W'($signed(mat_entry(job_ff, dsel_ff, plan.a_idx)));
      end
      if (plan.negate) mcand = -mcand;

      q_pop          = (state_ff == BK_IDLE) && !q_empty;
      mul_cmd.start  = state_ff == BK_MUL_GO;
      mul_cmd.mcand  = mcand;
      mul_cmd.mplier = mat_entry(job_ff, dsel_ff, plan.b_idx);
      mul_cmd.init   = plan.clear ? '0 : acc_ff;

      // restoring division, one quotient bit a cycle
      rtry     = {rem_ff[DET_W-1:0], num_ff[DIV_N-1]};
      ge       = rtry >= {1'b0, den_ff};
      rem_in   = ge ? rtry - {1'b0, den_ff} : rtry;
      div_last = dcnt_ff == DIV_CNT_W'(DIV_N - 1);
      q_fin    = {quo_ff[SOL_W-2:0], ge};
      big_fin  = big_ff || quo_ff[SOL_W-1];
      if (neg_ff) begin
         sol_sat = big_fin || (q_fin > SOL_MIN);
         sol_val = sol_sat ? SOL_MIN : -q_fin;
      end else begin
         sol_sat = big_fin || q_fin[SOL_W-1];
         sol_val = sol_sat ? SOL_MAX : q_fin;
      end

      out_valid_in = out_valid_ff;
      if (state_ff == BK_EMIT && out_free) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      rsp_empty = !out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               job_ff  <= q_data;
               step_ff <= '0;
               dsel_ff <= DSEL_DET;
               sat_ff  <= 1'b0;
               sing_ff <= 1'b0;
            end
         end
         BK_MUL_WAIT: begin
            if (mul_rsp.done) begin
               acc_ff <= mul_rsp.acc;
               if (step_ff[0] && step_ff < STEP_W'(6)) t_ff[step_ff[2:1]] <= mul_rsp.acc;
               if (!step_end) begin
                  step_ff <= step_ff + STEP_W'(1);
               end else begin
                  step_ff <= '0;
                  if (dsel_ff == DSEL_DET) begin
                     det_ff    <= mul_rsp.acc;
                     sing_ff   <= det_zero;
                     dsel_ff   <= dsel_ff + DSEL_W'(1);
                     sol_ff[0] <= '0;
                     sol_ff[1] <= '0;
                     sol_ff[2] <= '0;
                  end else begin
                     num_ff  <= {res_mag, Q_FRAC'(0)};
                     den_ff  <= det_mag;
                     rem_ff  <= '0;
                     quo_ff  <= '0;
                     big_ff  <= 1'b0;
                     neg_ff  <= mul_rsp.acc[DET_W-1] ^ det_ff[DET_W-1];
                     dcnt_ff <= '0;
                  end
               end
            end
         end
         BK_DIV: begin
            num_ff  <= num_ff << 1;
            rem_ff  <= rem_in;
            quo_ff  <= q_fin;
            big_ff  <= big_fin;
            dcnt_ff <= dcnt_ff + DIV_CNT_W'(1);
            if (div_last) begin
               sol_ff[dsel_ff - 2'd1] <= sol_val;
               sat_ff  <= sat_ff || sol_sat;
               dsel_ff <= dsel_ff + DSEL_W'(1);
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_solution_0 <= sol_ff[0];
               rsp_solution_1 <= sol_ff[1];
               rsp_solution_2 <= sol_ff[2];
               rsp_singular   <= sing_ff;
               rsp_saturated  <= sat_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/least_squares_3_unknowns.sv =====
// Top level of the streaming 3-unknown least squares solver.
// Depends on lsq3_pkg, lsq3_front, lsq3_queue, lsq3_mul, lsq3_back.
//
//   channel   ports                                   transfer when
//   request   req_coef_0..2 req_target req_last_row   req_push && !req_full
//   response  rsp_solution_0..2 rsp_singular          !rsp_empty && rsp_pop
//             rsp_saturated
//
// Rows are accumulated one per cycle in the front end while req_full is low. A last row hands
// the sums to a two-entry queue; the solver computes the determinants on the serial MAC and
// the quotients with bit-serial divides. req_full rises only while two solves are queued.
// Synchronous active-high reset clears the sums, the queue and the result slot.
module least_squares_3_unknowns (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [lsq3_pkg::SAMPLE_WIDTH-1:0] req_coef_0,
   input  logic signed [lsq3_pkg::SAMPLE_WIDTH-1:0] req_coef_1,
   input  logic signed [lsq3_pkg::SAMPLE_WIDTH-1:0] req_coef_2,
   input  logic signed [lsq3_pkg::SAMPLE_WIDTH-1:0] req_target,
   input  logic                                 req_last_row,
   input  logic                                 rsp_pop,
   output logic                                 rsp_empty,
   output logic signed [lsq3_pkg::SOL_W-1:0]    rsp_solution_0,
   output logic signed [lsq3_pkg::SOL_W-1:0]    rsp_solution_1,
   output logic signed [lsq3_pkg::SOL_W-1:0]    rsp_solution_2,
   output logic                                 rsp_singular,
   output logic                                 rsp_saturated
);
   import lsq3_pkg::*;

   logic        q_full, q_push, q_pop, q_empty;
   sums_type    q_wdata, q_rdata;
   mul_cmd_type mul_cmd;
   mul_rsp_type mul_rsp;

   lsq3_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_coef_0   (req_coef_0),
      .req_coef_1   (req_coef_1),
      .req_coef_2   (req_coef_2),
      .req_target   (req_target),
      .req_last_row (req_last_row),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_wdata)
   );

   lsq3_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .data_out (q_rdata)
   );

   lsq3_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   lsq3_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_data         (q_rdata),
      .q_pop          (q_pop),
      .mul_cmd        (mul_cmd),
      .mul_rsp        (mul_rsp),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_solution_0 (rsp_solution_0),
      .rsp_solution_1 (rsp_solution_1),
      .rsp_solution_2 (rsp_solution_2),
      .rsp_singular   (rsp_singular),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

// ===== sv/lsq3_checker.sv =====
// Port-level checks for least_squares_3_unknowns, attached with a bind.
// Depends on lsq3_pkg.
module lsq3_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_full,
   input logic                                 rsp_pop,
   input logic                                 rsp_empty,
   input logic signed [lsq3_pkg::SOL_W-1:0]    rsp_solution_0,
   input logic signed [lsq3_pkg::SOL_W-1:0]    rsp_solution_1,
   input logic signed [lsq3_pkg::SOL_W-1:0]    rsp_solution_2,
   input logic                                 rsp_singular,
   input logic                                 rsp_saturated
);
   import lsq3_pkg::*;

   // result slot is empty and input open right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("result shown or input blocked after reset");

   // a waiting result stays put until taken: its three solution values are checked
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty
         && rsp_solution_0 == $past(rsp_solution_0)
         && rsp_solution_1 == $past(rsp_solution_1)
         && rsp_solution_2 == $past(rsp_solution_2)))
      else $error("waiting result changed");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_singular) |-> (rsp_solution_0 == 0 && rsp_solution_1 == 0
         && rsp_solution_2 == 0 && !rsp_saturated))
      else $error("singular result not cleared");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_saturated) |->
         (rsp_solution_0 == SOL_MAX || rsp_solution_0 == SOL_MIN
          || rsp_solution_1 == SOL_MAX || rsp_solution_1 == SOL_MIN
          || rsp_solution_2 == SOL_MAX || rsp_solution_2 == SOL_MIN))
      else $error("saturation flag without clipped value");

endmodule

bind least_squares_3_unknowns lsq3_checker u_lsq3_checker (.*);

// ===== tb/tb_least_squares_3_unknowns.sv =====
// Self-checking testbench for least_squares_3_unknowns: streams row sets, predicts each
// solve with exact wide-integer Cramer's rule and checks every result transaction.
// Depends on lsq3_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_least_squares_3_unknowns;
   import lsq3_pkg::*;

   localparam int WIDE = 256;
   localparam int HOLD_CYCLES = 8000;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
   typedef logic signed [WIDE-1:0] wide_t;

   typedef struct {
      sample_t c0, c1, c2, tgt;
      logic    last;
   } row_t;

   typedef struct {
      logic [SOL_W-1:0] sol0, sol1, sol2;
      logic             sing, sat;
   } solve_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   sample_t req_coef_0 = '0, req_coef_1 = '0, req_coef_2 = '0, req_target = '0;
   logic req_last_row = 1'b0;
   logic rsp_pop = 1'b0;
   logic rsp_empty;
   logic signed [SOL_W-1:0] rsp_solution_0, rsp_solution_1, rsp_solution_2;
   logic rsp_singular, rsp_saturated;

   least_squares_3_unknowns dut (.*);

   always #1 clock = ~clock;

   row_t   pending_rows[$];
   solve_t expected_solves[$];
   int     send_idle_pct = 0, recv_stall_pct = 0;
   int     hold_count = 0;
   logic   hold_arm = 1'b0;
   int     errors = 0, solves_checked = 0, rows_sent = 0, singular_seen = 0, sat_seen = 0;
   logic   row_taken = 1'b0;

   // accumulator state of the predictor
   longint nrm_acc[6];
   longint rhs_acc[3];
   int     rows_acc = 0;

   function automatic wide_t det3(wide_t a0, wide_t a1, wide_t a2, wide_t a3, wide_t a4,
                                  wide_t a5, wide_t a6, wide_t a7, wide_t a8);
      return a0 * (a4 * a8 - a5 * a7) - a1 * (a3 * a8 - a5 * a6) + a2 * (a3 * a7 - a4 * a6);
   endfunction

   function automatic logic [SOL_W-1:0] q16_div(wide_t num, wide_t den, inout logic sat);
      logic neg;
      logic [WIDE-1:0] mn, md, q;
      neg = (num < 0) != (den < 0);
      mn = (num < 0) ? -num : num;
      md = (den < 0) ? -den : den;
      q = (mn << Q_FRAC) / md;
      if (neg) begin
         if (q > 256'h8000_0000) begin
            sat = 1'b1;
            return SOL_MIN;
         end
         return -q[SOL_W-1:0];
      end
      if (q > 256'h7FFF_FFFF) begin
         sat = 1'b1;
         return SOL_MAX;
      end
      return q[SOL_W-1:0];
   endfunction

   task automatic accumulate_row(row_t r);
      longint c0, c1, c2, t;
      wide_t s00, s01, s02, s11, s12, s22, b0, b1, b2, d;
      solve_t e;
      c0 = r.c0; c1 = r.c1; c2 = r.c2; t = r.tgt;
      if (rows_acc < MAX_ROWS) begin
         nrm_acc[0] += c0 * c0; nrm_acc[1] += c0 * c1; nrm_acc[2] += c0 * c2;
         nrm_acc[3] += c1 * c1; nrm_acc[4] += c1 * c2; nrm_acc[5] += c2 * c2;
         rhs_acc[0] += c0 * t; rhs_acc[1] += c1 * t; rhs_acc[2] += c2 * t;
         rows_acc++;
      end
      if (!r.last) return;
      s00 = nrm_acc[0]; s01 = nrm_acc[1]; s02 = nrm_acc[2];
      s11 = nrm_acc[3]; s12 = nrm_acc[4]; s22 = nrm_acc[5];
      b0 = rhs_acc[0]; b1 = rhs_acc[1]; b2 = rhs_acc[2];
      d = det3(s00, s01, s02, s01, s11, s12, s02, s12, s22);
      e = '{default: '0};
      if (d == 0) begin
         e.sing = 1'b1;
      end else begin
         e.sol0 = q16_div(det3(b0, s01, s02, b1, s11, s12, b2, s12, s22), d, e.sat);
         e.sol1 = q16_div(det3(s00, b0, s02, s01, b1, s12, s02, b2, s22), d, e.sat);
         e.sol2 = q16_div(det3(s00, s01, b0, s01, s11, b1, s02, s12, b2), d, e.sat);
      end
      expected_solves.push_back(e);
      nrm_acc = '{default: 0};
      rhs_acc = '{default: 0};
      rows_acc = 0;
   endtask

   task automatic report_mismatch(string what, logic [SOL_W-1:0] got, logic [SOL_W-1:0] want);
      errors++;
      $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   // long receiver hold-off, counted in its own process
   always @(posedge clock) begin
      if (hold_arm && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
   end

   // handshakes sampled at the rising edge
   always @(posedge clock) begin
      row_taken <= req_push && !req_full;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_solves.size() == 0) begin
            report_mismatch("unexpected result transaction", rsp_solution_0, '0);
         end else begin
            solve_t e;
            e = expected_solves.pop_front();
            if (rsp_solution_0 !== e.sol0) report_mismatch("solution_0", rsp_solution_0, e.sol0);
            if (rsp_solution_1 !== e.sol1) report_mismatch("solution_1", rsp_solution_1, e.sol1);
            if (rsp_solution_2 !== e.sol2) report_mismatch("solution_2", rsp_solution_2, e.sol2);
            if (rsp_singular !== e.sing) report_mismatch("singular", rsp_singular, e.sing);
            if (rsp_saturated !== e.sat) report_mismatch("saturated", rsp_saturated, e.sat);
            solves_checked++;
            singular_seen += e.sing;
            sat_seen += e.sat;
         end
      end
   end

   // driver: retire the accepted row, then decide on the next offer
   always @(negedge clock) begin
      row_t r;
      logic offer;
      if (row_taken) begin
         r = pending_rows.pop_front();
         accumulate_row(r);
         rows_sent++;
      end
      offer = !reset && pending_rows.size() > 0 && ($urandom_range(99) >= send_idle_pct);
      req_push <= offer;
      if (offer) begin
         r = pending_rows[0];
         req_coef_0 <= r.c0; req_coef_1 <= r.c1; req_coef_2 <= r.c2;
         req_target <= r.tgt; req_last_row <= r.last;
      end
      rsp_pop <= !reset && !(hold_arm && hold_count < HOLD_CYCLES)
                 && ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic sample_t pick_sample(int mode);
      case (mode)
         0: return sample_t'($urandom);
         1: return sample_t'($signed($urandom_range(8)) - 4);
         2: return $urandom_range(1) ? sample_t'(16'h7FFF - $urandom_range(3))
                                     : sample_t'(16'h8000 + $urandom_range(3));
         default: return sample_t'($signed($urandom_range(400)) - 200);
      endcase
   endfunction

   task automatic add_row(sample_t c0, sample_t c1, sample_t c2, sample_t t, logic last);
      row_t r;
      r = '{c0: c0, c1: c1, c2: c2, tgt: t, last: last};
      pending_rows.push_back(r);
   endtask

   task automatic add_random_set(int nrows, int mode);
      sample_t c0, c1, c2, t;
      int x0, x1, x2;
      x0 = $signed($urandom_range(20)) - 10;
      x1 = $signed($urandom_range(20)) - 10;
      x2 = $signed($urandom_range(20)) - 10;
      for (int i = 0; i < nrows; i++) begin
         c0 = pick_sample(mode); c1 = pick_sample(mode); c2 = pick_sample(mode);
         // in modes 1 and 3 mostly a consistent model plus noise, else a free target
         if ($urandom_range(3) != 0 && mode != 0 && mode != 2)
            t = sample_t'(x0 * c0 + x1 * c1 + x2 * c2 + $signed($urandom_range(6)) - 3);
         else
            t = pick_sample(mode);
         add_row(c0, c1, c2, t, i == nrows - 1);
      end
   endtask

   task automatic drain();
      while (pending_rows.size() > 0 || expected_solves.size() > 0) @(posedge clock);
   endtask

   initial begin
      int sets_left;
      nrm_acc = '{default: 0};
      rhs_acc = '{default: 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, singular and short sets, clean solve, saturation
      add_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
      add_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
      add_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1);
      add_row(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      add_row(16'sd2, 16'sd0, 16'sd0, 16'sd6, 1'b0);
      add_row(16'sd0, -16'sd4, 16'sd0, 16'sd3, 1'b0);
      add_row(16'sd0, 16'sd0, 16'sd1, -16'sd7, 1'b1);
      add_row(16'sd1, 16'sd0, 16'sd0, 16'sh7FFF, 1'b0);
      add_row(16'sd0, 16'sd1, 16'sd0, 16'sh8000, 1'b0);
      add_row(16'sd0, 16'sd0, -16'sd1, 16'sh8000, 1'b1);
      add_row(16'sh7FFF, 16'sh7FFE, 16'sd0, 16'sh7FFF, 1'b0);
      add_row(16'sh7FFE, 16'sh7FFD, 16'sd0, 16'sh8000, 1'b0);
      add_row(16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b1);
      add_row(16'sh5555, -16'sh2AAA, 16'sh7FFF, 16'sh0001, 1'b0);
      add_row(-16'sh5555, 16'sh2AAA, 16'sh8000, -16'sh0001, 1'b0);
      add_row(16'sh1234, 16'sh7001, -16'sh0F0F, 16'sh4321, 1'b1);
      drain();

      // receiver holds off while short sets keep coming until the input stalls
      hold_arm = 1'b1;
      for (int i = 0; i < 5; i++) add_random_set(3, 3);
      drain();

      // row limit: more rows than the sums take, then solve on what was held
      add_random_set(MAX_ROWS + 6, 1);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin send_idle_pct = 84; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 84; end
            3: begin send_idle_pct = 32; recv_stall_pct = 32; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         sets_left = 18;
         while (sets_left > 0) begin
            add_random_set($urandom_range(7) == 0 ? $urandom_range(2, 1) : $urandom_range(6, 3),
                           $urandom_range(3));
            sets_left--;
         end
         drain();
      end

      repeat (2500) @(posedge clock);
      $display("Run covered %0d rows and %0d solves (%0d singular, %0d saturated).",
               rows_sent, solves_checked, singular_seen, sat_seen);
      $display("Idle phases on both channels and a long receiver hold-off were exercised.");
      if (errors == 0 && expected_solves.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d solves outstanding.", expected_solves.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
